[rtl/core/pff_pkg.sv]
// ============================================================================
// pff_pkg
// Shared types and constants of the polyphase filterbank FIR front end.
// ============================================================================
package pff_pkg;

    // Configuration port
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int CH_CFG_W     = 9;
    localparam int TAP_CFG_W    = 4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAPS     = 2'd1;

    // Register reset values
    localparam int RST_CHANNELS = 256;
    localparam int RST_TAPS     = 8;

    // Field widths fixed by the interface
    localparam int COEFF_IDX_W = 11;
    localparam int CHAN_IDX_W  = 8;
    localparam int ACC_W       = 35;
    localparam int OUT_DATA_W  = ((CHAN_IDX_W + ACC_W + 7) / 8) * 8;

    // Request kinds carried in tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEFF  = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

[rtl/core/polyphase_fir_frontend.sv]
// ============================================================================
// polyphase_fir_frontend
// Polyphase filterbank FIR stage: sample delay store, coefficient table and
// a tap-serial multiply-accumulate sequencer.
// ============================================================================
// Usage
//   Slave stream: tuser selects the item kind (0 = sample, 1 = coefficient
//   write). A coefficient write or a sample that does not yet complete a
//   filter window gives no result and leaves the block idle.
//   A sample that completes a window starts a job: the T tap pairs are read
//   from the sample and coefficient memories one pair per cycle (one read
//   port each), registered, multiplied into a product register and summed
//   in the accumulator; the sum is then loaded into the output register for
//   the master stream. No new item is taken until the job is through and
//   the sequencer is back in idle.
//   The result sits in an output register; a new item may be accepted while
//   it waits. If the receiver still stalls when the next sum is ready, the
//   sequencer holds that sum and takes no item until the register frees.
//   tlast marks the last channel of a spectrum.
//   Reset (synchronous, active low) and a channels or taps write restart the
//   stream: write position, channel counter and fill count return to zero.
//   Memory contents are not cleared; coefficients must be written before use.
//   The user writes configuration only while the block is idle; not enforced.
// ============================================================================
module polyphase_fir_frontend
    import pff_pkg::*;
#(
    parameter int CHANNELS    = 256,
    parameter int TAPS        = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]           i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]           i_cfg_wdata,
    // Slave stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: sample_value, coeff_index, coeff_value, zero pad
    input  logic [((2*SAMPLE_BITS+COEFF_IDX_W+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: req_type
    input  logic                            i_s_axis_tuser,
    // Master stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: channel_index, filtered_value, zero pad
    output logic [OUT_DATA_W-1:0]           o_m_axis_tdata,
    output logic                            o_m_axis_tlast
);

    localparam int D   = CHANNELS * TAPS;
    localparam int AW  = $clog2(D);
    localparam int FW  = $clog2(D + 1);
    localparam int CW  = $clog2(CHANNELS + 1);
    localparam int TW  = $clog2(TAPS + 1);
    localparam int OCW = $clog2(CHANNELS);
    localparam int SB  = SAMPLE_BITS;
    localparam int RST_C_EFF = (RST_CHANNELS > CHANNELS) ? CHANNELS : RST_CHANNELS;
    localparam int RST_T_EFF = (RST_TAPS > TAPS) ? TAPS : RST_TAPS;

    // Memories
    logic signed [SB-1:0] r_smem [0:D-1];
    logic signed [SB-1:0] r_cmem [0:D-1];

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_ch;
    logic [TW-1:0]   r_tp;
    logic [AW-1:0]   r_wp;
    logic [OCW-1:0]  r_oc;
    logic [FW-1:0]   r_fill;
    logic [TW-1:0]   r_z;
    logic [AW-1:0]   r_rd_s;
    logic [AW-1:0]   r_rd_c;
    logic            r_p1_v, r_p1_first, r_p1_last;
    logic            r_p2_v, r_p2_first, r_p2_last;
    logic            r_done;
    logic            r_out_v;

    // Payload registers
    logic signed [SB-1:0]   r_s_q, r_c_q;
    logic signed [2*SB-1:0] r_prod;
    logic [ACC_W-1:0]       r_acc;
    logic [OCW-1:0]         r_job_ch;
    logic                   r_job_last;
    logic [CHAN_IDX_W-1:0]  r_out_ch;
    logic [ACC_W-1:0]       r_out_val;
    logic                   r_out_last;

    // Field unpacking
    logic signed [SB-1:0]   w_sample;
    logic [COEFF_IDX_W-1:0] w_cidx;
    logic signed [SB-1:0]   w_cval;
    assign w_sample = i_s_axis_tdata[SB-1:0];
    assign w_cidx   = i_s_axis_tdata[SB +: COEFF_IDX_W];
    assign w_cval   = i_s_axis_tdata[SB+COEFF_IDX_W +: SB];

    // Window span (T-1)*C and derived quantities
    logic [TW+CW-1:0] w_span_full;
    logic [AW-1:0]    w_span;
    assign w_span_full = (TW+CW)'(r_tp - TW'(1)) * (TW+CW)'(r_ch);
    assign w_span      = AW'(w_span_full);

    logic w_acc_in, w_sample_acc, w_coeff_acc, w_job;
    assign w_acc_in     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sample_acc = w_acc_in && (i_s_axis_tuser == REQ_SAMPLE);
    assign w_coeff_acc  = w_acc_in && (i_s_axis_tuser == REQ_COEFF);
    assign w_job        = w_sample_acc && (r_fill >= FW'(w_span));

    // Oldest tap address of the window ending at the current write position
    logic [AW:0] w_start;
    always_comb begin
        if (r_wp >= w_span) begin
            w_start = (AW+1)'(r_wp) - (AW+1)'(w_span);
        end else begin
            w_start = (AW+1)'(r_wp) + (AW+1)'(D) - (AW+1)'(w_span);
        end
    end

    // Tap address stepping
    logic [AW:0]   w_rs_sum;
    logic [AW-1:0] w_rs_next;
    assign w_rs_sum  = (AW+1)'(r_rd_s) + (AW+1)'(r_ch);
    assign w_rs_next = (w_rs_sum >= (AW+1)'(D)) ? AW'(w_rs_sum - (AW+1)'(D)) : AW'(w_rs_sum);

    logic w_last_tap, w_oc_wrap, w_out_free;
    assign w_last_tap = (r_z == r_tp - TW'(1));
    assign w_oc_wrap  = ((CW'(r_oc) + CW'(1)) == r_ch);
    assign w_out_free = !r_out_v || i_m_axis_tready;

    // Configuration clamping
    logic [CW-1:0] w_cfg_ch;
    logic [TW-1:0] w_cfg_tp;
    always_comb begin
        if (i_cfg_wdata[CH_CFG_W-1:0] == '0) begin
            w_cfg_ch = CW'(1);
        end else if (32'(i_cfg_wdata[CH_CFG_W-1:0]) > CHANNELS) begin
            w_cfg_ch = CW'(CHANNELS);
        end else begin
            w_cfg_ch = CW'(i_cfg_wdata[CH_CFG_W-1:0]);
        end
        if (i_cfg_wdata[TAP_CFG_W-1:0] == '0) begin
            w_cfg_tp = TW'(1);
        end else if (32'(i_cfg_wdata[TAP_CFG_W-1:0]) > TAPS) begin
            w_cfg_tp = TW'(TAPS);
        end else begin
            w_cfg_tp = TW'(i_cfg_wdata[TAP_CFG_W-1:0]);
        end
    end

    // Sequencer: next state and strobes
    logic w_issue, w_load;
    always_comb begin
        n_state = r_state;
        w_issue = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_job) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                w_issue = 1'b1;
                if (w_last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_done && w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stream position, configuration and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch    <= CW'(RST_C_EFF);
            r_tp    <= TW'(RST_T_EFF);
            r_wp    <= '0;
            r_oc    <= '0;
            r_fill  <= '0;
            r_z     <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_done  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            // configuration write restarts the stream
            if (i_cfg_we && (i_cfg_addr == REG_CHANNELS || i_cfg_addr == REG_TAPS)) begin
                if (i_cfg_addr == REG_CHANNELS) begin
                    r_ch <= w_cfg_ch;
                end else begin
                    r_tp <= w_cfg_tp;
                end
                r_wp   <= '0;
                r_oc   <= '0;
                r_fill <= '0;
            end else if (w_sample_acc) begin
                r_wp <= (r_wp == AW'(D - 1)) ? '0 : r_wp + AW'(1);
                if (r_fill <= FW'(w_span)) begin
                    r_fill <= r_fill + FW'(1);
                end
                if (w_job) begin
                    r_oc <= w_oc_wrap ? '0 : r_oc + OCW'(1);
                end
            end

            // tap counter
            if (w_job) begin
                r_z <= '0;
            end else if (w_issue) begin
                r_z <= r_z + TW'(1);
            end

            r_p1_v <= w_issue;
            r_p2_v <= r_p1_v;

            if (w_load) begin
                r_done <= 1'b0;
            end else if (r_p2_v && r_p2_last) begin
                r_done <= 1'b1;
            end

            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Job set-up and tap address stepping
    always_ff @(posedge i_clk) begin
        if (w_job) begin
            r_rd_s     <= AW'(w_start);
            r_rd_c     <= AW'(r_oc);
            r_job_ch   <= r_oc;
            r_job_last <= w_oc_wrap;
        end else if (w_issue) begin
            r_rd_s <= w_rs_next;
            r_rd_c <= r_rd_c + AW'(r_ch);
        end
    end

    // Sample store: write on sample item, read one tap per cycle
    always_ff @(posedge i_clk) begin
        if (w_sample_acc) begin
            r_smem[r_wp] <= w_sample;
        end
        if (w_issue) begin
            r_s_q <= r_smem[r_rd_s];
        end
    end

    // Coefficient table: slots beyond the table are dropped
    always_ff @(posedge i_clk) begin
        if (w_coeff_acc && (32'(w_cidx) < D)) begin
            r_cmem[AW'(w_cidx)] <= w_cval;
        end
        if (w_issue) begin
            r_c_q <= r_cmem[r_rd_c];
        end
    end

    // Multiply and accumulate (wraps at the output width)
    always_ff @(posedge i_clk) begin
        r_p1_first <= (r_z == '0);
        r_p1_last  <= w_last_tap;
        r_prod     <= r_s_q * r_c_q;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        if (r_p2_v) begin
            if (r_p2_first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ch   <= CHAN_IDX_W'(r_job_ch);
            r_out_val  <= r_acc;
            r_out_last <= r_job_last;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_val, r_out_ch});

    // Checks
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_p1_v && !r_p2_v && !r_done))
        else $error("pipeline busy while sequencer idle");

    a_fill_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(w_span) + FW'(1))
        else $error("fill count beyond window length");

    a_oc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_oc) < r_ch)
        else $error("channel counter out of range");

    a_tap_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> ((32'(r_rd_s) < D) && (32'(r_rd_c) < D)))
        else $error("tap address beyond store");

    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !$past(r_out_v)) |-> ($past(r_state) == ST_DRAIN))
        else $error("result appeared outside drain");

endmodule

[verif/pff_output_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// pff_output_checker
// Passive checker for the polyphase FIR front end. It follows register
// writes and accepted input items, keeps its own copy of the delay store
// and coefficient table, predicts every filter output and compares each
// delivered output with the oldest prediction.
// ============================================================================
module pff_output_checker
    import pff_pkg::*;
#(
    parameter int CHANNELS    = 256,
    parameter int TAPS        = 8,
    parameter int SAMPLE_BITS = 16,
    parameter int IN_W        = ((2*SAMPLE_BITS+COEFF_IDX_W+7)/8)*8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Input stream
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // tdata: sample_value, coeff_index, coeff_value, zero pad
    input  logic [IN_W-1:0]       i_s_tdata,
    // tuser: req_type
    input  logic                  i_s_tuser,
    // Output stream
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // tdata: channel_index, filtered_value, zero pad
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tlast,
    // Status towards the testbench top
    output logic [31:0]           o_fail_count,
    output logic [31:0]           o_pending,
    output logic [31:0]           o_checked
);

    localparam int DEPTH       = CHANNELS * TAPS;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CHAN_IDX_W-1:0] channel;
        logic [ACC_W-1:0]      value;
        logic                  last;
    } t_filter_out;

    // Predicted outputs, oldest first
    t_filter_out expected_outputs[$];

    logic signed [SAMPLE_BITS-1:0] sample_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] coeff_mem  [DEPTH];
    logic [CH_CFG_W-1:0]           channels_reg;
    logic [TAP_CFG_W-1:0]          taps_reg;
    int                            wr_pos;
    int                            out_chan;
    int                            fill;
    int                            fails;
    int                            checked;

    always @(posedge i_clk) begin : track
        int                     c;
        int                     t;
        int                     need;
        int                     cur;
        int                     pos;
        int                     z;
        longint                 acc;
        logic [COEFF_IDX_W-1:0] slot;
        t_filter_out            got;
        t_filter_out            exp_out;

        if (!i_rst_n) begin
            channels_reg = CH_CFG_W'(RST_CHANNELS);
            taps_reg     = TAP_CFG_W'(RST_TAPS);
            wr_pos       = 0;
            out_chan     = 0;
            fill         = 0;
            fails        = 0;
            checked      = 0;
            expected_outputs.delete();
        end else begin
            // Delivered output against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got.channel = i_m_tdata[CHAN_IDX_W-1:0];
                got.value   = i_m_tdata[CHAN_IDX_W +: ACC_W];
                got.last    = i_m_tlast;
                if (expected_outputs.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%t: output with nothing predicted: chan %0d value %0d last %b",
                                 $time, got.channel, $signed(got.value), got.last);
                end else begin
                    exp_out = expected_outputs.pop_front();
                    checked++;
                    if (got.channel !== exp_out.channel || got.value !== exp_out.value ||
                        got.last !== exp_out.last) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%t: mismatch: chan exp %0d got %0d, value exp %0d got %0d, last exp %b got %b",
                                     $time, exp_out.channel, got.channel,
                                     $signed(exp_out.value), $signed(got.value),
                                     exp_out.last, got.last);
                    end
                end
            end

            // Register writes restart the stream; spare indexes do nothing
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_CHANNELS) begin
                    channels_reg = i_cfg_wdata[CH_CFG_W-1:0];
                    wr_pos = 0;
                    out_chan = 0;
                    fill = 0;
                end else if (i_cfg_addr == REG_TAPS) begin
                    taps_reg = i_cfg_wdata[TAP_CFG_W-1:0];
                    wr_pos = 0;
                    out_chan = 0;
                    fill = 0;
                end
            end

            // Accepted input item
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == REQ_COEFF) begin
                    slot = i_s_tdata[SAMPLE_BITS +: COEFF_IDX_W];
                    if (slot < DEPTH)
                        coeff_mem[slot] = i_s_tdata[SAMPLE_BITS+COEFF_IDX_W +: SAMPLE_BITS];
                end else begin
                    // zero acts as one, oversize values clip to the build size
                    c = (channels_reg == 0) ? 1 :
                        (channels_reg > CHANNELS) ? CHANNELS : int'(channels_reg);
                    t = (taps_reg == 0) ? 1 :
                        (taps_reg > TAPS) ? TAPS : int'(taps_reg);
                    need = (t - 1) * c + 1;
                    cur = wr_pos;
                    sample_mem[cur] = i_s_tdata[SAMPLE_BITS-1:0];
                    wr_pos = (cur + 1) % DEPTH;
                    if (fill < need)
                        fill++;
                    if (fill >= need) begin
                        if (out_chan >= c)
                            out_chan = 0;
                        // newest sample pairs with the last tap row
                        acc = 0;
                        for (z = 0; z < t; z++) begin
                            pos = (cur + DEPTH - (t - 1 - z) * c) % DEPTH;
                            acc += longint'(coeff_mem[out_chan + z * c]) *
                                   longint'(sample_mem[pos]);
                        end
                        exp_out.channel = CHAN_IDX_W'(out_chan);
                        exp_out.value   = acc[ACC_W-1:0];
                        exp_out.last    = (out_chan == c - 1);
                        expected_outputs.push_back(exp_out);
                        out_chan++;
                        if (out_chan >= c)
                            out_chan = 0;
                    end
                end
            end
        end

        o_fail_count <= fails;
        o_pending    <= expected_outputs.size();
        o_checked    <= checked;
    end

endmodule

[verif/tb_polyphase_fir_frontend.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_polyphase_fir_frontend
// Stimulus and verdict for the polyphase FIR front end. Runs a directed
// burst at full-scale values, then random sample and coefficient traffic
// over a range of channel and tap settings, with random idling on both
// streams, a long output stall and a full drain pause.
// ============================================================================
module tb_polyphase_fir_frontend;
    import pff_pkg::*;

    localparam int CHANNELS    = 256;
    localparam int TAPS        = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int IN_W        = ((2*SAMPLE_BITS+COEFF_IDX_W+7)/8)*8;
    localparam int DEPTH       = CHANNELS * TAPS;

    // Register indexes past the defined list
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int     RESET_CYCLES  = 5;
    localparam int     SETTLE_CYCLES = TAPS + 8;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint TIMEOUT_NS    = 5_000_000;

    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_MAX = ~S_MIN;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic [31:0]           fail_count;
    logic [31:0]           pending;
    logic [31:0]           checked;

    int         send_idle = 0;
    int         recv_idle = 0;
    bit         hold_req = 1'b0;
    bit         coeff_written [DEPTH];
    int         items_sent = 0;
    int         settings_run = 0;

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    polyphase_fir_frontend #(
        .CHANNELS    (CHANNELS),
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    pff_output_checker #(
        .CHANNELS    (CHANNELS),
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) out_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: random stalls, plus one long hold on request
    initial begin : receiver
        int n;

        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Mostly random values, with the full-scale ends and zero/minus one mixed in
    function automatic logic [SAMPLE_BITS-1:0] pick_value();
        case ($urandom_range(15))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // One input item, after a random gap
    task automatic send_item(input logic req, input logic [SAMPLE_BITS-1:0] samp,
                             input logic [COEFF_IDX_W-1:0] slot,
                             input logic [SAMPLE_BITS-1:0] cval);
        int gap;

        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(IN_W-2*SAMPLE_BITS-COEFF_IDX_W){1'b0}}, cval, slot, samp};
        do @(posedge clk); while (!s_tready);
        if (req == REQ_COEFF)
            coeff_written[slot] = 1'b1;
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every predicted output has been delivered
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One stream setting: drain, optional reconfigure, coefficient cover,
    // optional store prefill, then random traffic
    task automatic run_phase(input logic [CH_CFG_W-1:0] ch_val,
                             input logic [TAP_CFG_W-1:0] tap_val,
                             input bit reconfigure, input bit prefill,
                             input int n_items, input int hold_at, input int pause_at);
        int c;
        int t;
        int i;

        drain_outputs();
        if (reconfigure) begin
            write_reg(REG_CHANNELS, CFG_DATA_W'(ch_val));
            // upper data bits beyond the taps field are junk
            write_reg(REG_TAPS, {(CFG_DATA_W-TAP_CFG_W)'($urandom()), tap_val});
            settings_run++;
        end
        c = (ch_val == 0) ? 1 : (ch_val > CHANNELS) ? CHANNELS : int'(ch_val);
        t = (tap_val == 0) ? 1 : (tap_val > TAPS) ? TAPS : int'(tap_val);

        // every slot this setting reads must hold a coefficient
        for (i = 0; i < c * t; i++)
            if (!coeff_written[i])
                send_item(REQ_COEFF, pick_value(), COEFF_IDX_W'(i), pick_value());

        if (prefill)
            repeat ((t - 1) * c)
                send_item(REQ_SAMPLE, pick_value(),
                          COEFF_IDX_W'($urandom_range(DEPTH-1)), pick_value());

        for (i = 0; i < n_items; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                drain_outputs();
            send_item(($urandom_range(99) < 10) ? REQ_COEFF : REQ_SAMPLE, pick_value(),
                      COEFF_IDX_W'($urandom_range(DEPTH-1)), pick_value());
        end
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int i;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_SAMPLE;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one channel, all taps, full-scale products
        send_idle = 6;
        recv_idle = 65;
        write_reg(REG_CHANNELS, CFG_DATA_W'(1));
        write_reg(REG_TAPS, CFG_DATA_W'(TAPS));
        settings_run++;
        for (i = 0; i < TAPS; i++)
            send_item(REQ_COEFF, S_MAX, COEFF_IDX_W'(i), S_MIN);
        send_item(REQ_COEFF, S_MIN, COEFF_IDX_W'(DEPTH-1), S_MAX);
        // largest positive sum, then opposite signs
        repeat (TAPS + 1) send_item(REQ_SAMPLE, S_MIN, '1, S_MAX);
        repeat (4) send_item(REQ_SAMPLE, S_MAX, '0, S_MIN);
        // coefficient change while the stream is running
        send_item(REQ_COEFF, '0, COEFF_IDX_W'(3), S_MAX);
        send_item(REQ_SAMPLE, '1, '0, '0);
        send_item(REQ_SAMPLE, '0, '1, '1);
        send_item(REQ_SAMPLE, SAMPLE_BITS'(1), '0, '0);

        // Random traffic, slow receiver; long output stall in the 256-channel run
        run_phase(CH_CFG_W'(4), TAP_CFG_W'(2), 1'b1, 1'b0, 100, -1, -1);
        run_phase(CH_CFG_W'(0), TAP_CFG_W'(0), 1'b1, 1'b0, 60, -1, -1);
        run_phase(CH_CFG_W'(511), TAP_CFG_W'(1), 1'b1, 1'b0, 150, 60, -1);

        // Slow sender
        send_idle = 65;
        recv_idle = 6;
        run_phase(CH_CFG_W'(7), TAP_CFG_W'(15), 1'b1, 1'b0, 100, -1, -1);
        // spare register indexes leave the stream running
        drain_outputs();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom()));
        run_phase(CH_CFG_W'(7), TAP_CFG_W'(15), 1'b0, 1'b0, 50, -1, -1);
        run_phase(CH_CFG_W'(5), TAP_CFG_W'(3), 1'b1, 1'b1, 80, -1, -1);

        // No idling; drain pause mid-run, then all taps over a prefilled store
        send_idle = 0;
        recv_idle = 0;
        run_phase(CH_CFG_W'(3), TAP_CFG_W'(5), 1'b1, 1'b0, 100, -1, 50);
        run_phase(CH_CFG_W'(16), TAP_CFG_W'(TAPS), 1'b1, 1'b1, 100, -1, -1);

        drain_outputs();

        $display("Run summary: %0d stream settings, %0d items sent, %0d filter outputs checked.",
                 settings_run, items_sent, checked);
        $display("Run summary: clipped and spare register writes, full-scale sums, long stall, drain pause.");
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pff_pkg.sv
rtl/core/polyphase_fir_frontend.sv
verif/pff_output_checker.sv
verif/tb_polyphase_fir_frontend.sv
